// File: rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`default_nettype none

package spq_pkg;

  // Built depth of the key row and reset capacity
  localparam int unsigned SPQ_DEPTH     = 16;
  localparam int unsigned CAP_W         = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef logic signed [31:0] key_t;

  // Request opcodes
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Request payload
  typedef struct packed {
    logic  opcode;
    key_t  key_value;
  } spq_req_t;

  // Result payload
  typedef struct packed {
    key_t         removed_value;
    key_t         min_value;
    logic [1:0]   status;
    logic [4:0]   entry_count;
    logic         is_empty;
    logic         is_full;
  } spq_res_t;

  // Per-cell control from the row controller
  typedef struct packed {
    logic ins;      // insert takes effect this cycle
    logic occ;      // cell holds a stored key
    logic tail;     // cell is the first free slot
    logic prev_gt;  // left neighbor is shifting right
  } spq_cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/spq_cell.sv
// One storage cell of the sorted key row.
`default_nettype none

module spq_cell import spq_pkg::*; (
  input  wire           clk_i,
  input  spq_cell_ctl_t ctl_i,
  input  key_t          key_i,
  input  key_t          prev_key_i,
  output key_t          key_o,
  output logic          gt_o
);

  key_t key_q, key_d;

  // New key sorts ahead of this stored key
  assign gt_o = ctl_i.occ && (key_i > key_q);

  // Take the neighbor's key on a shift, the new key at the insert point
  always_comb begin
    key_d = key_q;
    if (ctl_i.ins) begin
      if (ctl_i.prev_gt) begin
        key_d = prev_key_i;
      end else if (gt_o || ctl_i.tail) begin
        key_d = key_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

`default_nettype wire

// File: rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: cell row, count and result logic.
`default_nettype none

// Latency: the result strobes on done_o in the cycle after start is taken.
// Requests: start is not taken while busy is high; busy covers the cycle in
// which the tail of the cell row is read back for the new minimum.
// Reset: count clears to 0 and capacity to 16; cell keys hold no reset value.
// The receiver cannot stall: each result is shown for exactly one cycle.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned DEPTH = SPQ_DEPTH
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start,
  output logic             busy,
  input  spq_req_t         req_i,
  output logic             done_o,
  output spq_res_t         res_o,
  input  wire              cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire [CAP_W-1:0]  cfg_data_i
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned EW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0] cap_q;
  logic [CW-1:0]    count_q, count_d;
  logic             busy_q;
  key_t             removed_q, removed_d;
  status_e          status_q, status_d;

  logic [EW-1:0] cap_ext, eff_cap, count_ext;
  logic          full, empty, accept, ins_en;
  logic [CW-1:0] cnt_m1;
  logic [IW-1:0] tail_idx;
  key_t          tail_key;

  key_t keys [DEPTH];
  logic gt   [DEPTH];

  // Capacity saturates to the range 1..DEPTH
  assign cap_ext = EW'(cap_q);
  always_comb begin
    eff_cap = cap_ext;
    if (cap_ext == '0) begin
      eff_cap = EW'(1);
    end else if (cap_ext > EW'(DEPTH)) begin
      eff_cap = EW'(DEPTH);
    end
  end

  assign count_ext = EW'(count_q);
  assign full      = count_ext >= eff_cap;
  assign empty     = (count_q == '0);
  assign accept    = start && !busy_q;
  assign ins_en    = accept && (req_i.opcode == OP_INSERT) && !full;

  // Tail of the row: smallest stored key
  assign cnt_m1   = count_q - CW'(1);
  assign tail_idx = cnt_m1[IW-1:0];
  assign tail_key = keys[tail_idx];

  // Row of cells, each handing its key to the right on an insert shift
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_cell_ctl_t ctl;
    key_t          prev_key;
    if (i == 0) begin : g_head
      assign ctl.prev_gt = 1'b0;
      assign prev_key    = '0;
    end else begin : g_body
      assign ctl.prev_gt = gt[i-1];
      assign prev_key    = keys[i-1];
    end
    assign ctl.ins  = ins_en;
    assign ctl.occ  = CW'(i) < count_q;
    assign ctl.tail = count_q == CW'(i);

    spq_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .key_i      (req_i.key_value),
      .prev_key_i (prev_key),
      .key_o      (keys[i]),
      .gt_o       (gt[i])
    );
  end

  // Count update and result capture
  always_comb begin
    count_d   = count_q;
    removed_d = removed_q;
    status_d  = status_q;
    if (accept) begin
      removed_d = '0;
      status_d  = ST_OK;
      unique case (req_i.opcode)
        OP_REMOVE: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            removed_d = tail_key;
            count_d   = cnt_m1;
          end
        end
        OP_INSERT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            count_d = count_q + CW'(1);
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      busy_q   <= 1'b0;
      cap_q    <= CAP_RESET;
      status_q <= ST_OK;
    end else begin
      count_q  <= count_d;
      busy_q   <= accept;
      status_q <= status_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    removed_q <= removed_d;
  end

  // Result read back from the updated row
  assign busy        = busy_q;
  assign done_o      = busy_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    res_o.removed_value = removed_q;
    res_o.min_value     = empty ? key_t'(0) : tail_key;
    res_o.status        = status_q;
    res_o.entry_count   = count_ext[4:0];
    res_o.is_empty      = empty;
    res_o.is_full       = full;
  end

endmodule

`default_nettype wire
